### hw/rtl/fpat_pkg.sv
package fpat_pkg;

    localparam int unsigned MagW      = 32;
    localparam int unsigned FracW     = 16;
    localparam int unsigned QuotW     = FracW + 1;
    localparam int unsigned AngleW    = 16;

    localparam logic [AngleW-1:0] ZeroAngle = 16'hC000;
    localparam logic [AngleW-1:0] Quarter   = 16'h4000;
    localparam logic [AngleW-1:0] Half      = 16'h8000;
    localparam logic [15:0]       OctBase   = 16'h2000;
    localparam logic [15:0]       OctCurve  = 16'h0B20;
    localparam logic [QuotW-1:0]  FxOne     = 17'h10000;

    typedef struct packed {
        logic zero;
        logic mirror;
        logic negate;
        logic swap;
    } fold_t;

    // Partial remainder of the restoring divider, one bit wider than the divisor.
    typedef struct packed {
        logic           vld;
        fold_t          fold;
        logic [MagW:0]  rem;
        logic [MagW-1:0] dvs;
        logic [QuotW-1:0] quo;
    } div_t;

endpackage

### hw/rtl/fpat_div_cell.sv
// One restoring-division step: shift in a zero dividend bit, try subtract.
module fpat_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  fpat_pkg::div_t  d_in,
    output fpat_pkg::div_t  d_out
);
    logic [fpat_pkg::MagW+1:0] shf;
    logic [fpat_pkg::MagW+1:0] dif;
    fpat_pkg::div_t            d_reg;
    fpat_pkg::div_t            d_next;

    always_comb begin
        shf    = {d_in.rem, 1'b0};
        dif    = shf - {2'b00, d_in.dvs};
        d_next = d_in;
        if (!dif[fpat_pkg::MagW+1]) begin
            d_next.rem = dif[fpat_pkg::MagW:0];
            d_next.quo = {d_in.quo[fpat_pkg::QuotW-2:0], 1'b1};
        end else begin
            d_next.rem = shf[fpat_pkg::MagW:0];
            d_next.quo = {d_in.quo[fpat_pkg::QuotW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.vld <= 1'b0;
        end else if (en) begin
            d_reg.vld <= d_in.vld;
        end
        if (en) begin
            d_reg.fold <= d_next.fold;
            d_reg.rem  <= d_next.rem;
            d_reg.dvs  <= d_next.dvs;
            d_reg.quo  <= d_next.quo;
        end
    end

    assign d_out = d_reg;
endmodule

### hw/rtl/fpat_poly.sv
// Octant polynomial and unfold, three register stages.
module fpat_poly (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  fpat_pkg::fold_t               in_fold,
    input  logic [fpat_pkg::QuotW-1:0]    in_r,
    output logic                          out_vld,
    output logic [fpat_pkg::AngleW-1:0]   out_angle
);
    logic [2:0]                  vld_reg;
    fpat_pkg::fold_t             f1_reg, f2_reg;
    logic [fpat_pkg::QuotW-1:0]  r1_reg, r2_reg;
    logic [16:0]                 t1_reg;
    logic [16:0]                 b2_reg;
    logic [fpat_pkg::AngleW-1:0] ang_reg;
    logic [fpat_pkg::AngleW-1:0] ang_next;
    logic [33:0]                 p1, p2;
    logic [16:0]                 a2;

    // (1-r)*curve fits under 17 bits after the shift; r*(base+..) under 16 after it.
    assign p1 = {1'b0, fpat_pkg::FxOne - in_r} * {18'd0, fpat_pkg::OctCurve};
    assign p2 = {17'd0, r2_reg} * {17'd0, b2_reg};
    assign a2 = {1'b0, fpat_pkg::OctBase} + t1_reg;

    always_comb begin
        ang_next = p2[31:16];
        if (f2_reg.swap)   ang_next = fpat_pkg::Quarter - ang_next;
        if (f2_reg.mirror) ang_next = fpat_pkg::Half - ang_next;
        if (f2_reg.negate) ang_next = '0 - ang_next;
        if (f2_reg.zero)   ang_next = fpat_pkg::ZeroAngle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
        if (en) begin
            f1_reg  <= in_fold;
            r1_reg  <= in_r;
            t1_reg  <= p1[32:16];
            f2_reg  <= f1_reg;
            r2_reg  <= r1_reg;
            b2_reg  <= a2;
            ang_reg <= ang_next;
        end
    end

    assign out_vld   = vld_reg[2];
    assign out_angle = ang_reg;
endmodule

### hw/rtl/fixed_point_atan2_turns.sv
// fixed_point_atan2_turns: angle of a screen-space 16.16 vector in 1/65536 turns.
// Input channel s_valid/s_ready carries s_vec_x and s_vec_y (signed 16.16,
// y down positive). Result channel m_valid/m_ready carries m_angle.
// A zero vector gives 0xC000.
// Throughput: one vector per cycle unless stalled. From transfer to m_valid an
// item passes one fold stage (its output also decides the first quotient
// bit), a chain of 16 restoring-divider cells (one quotient bit each), three
// stages of polynomial and unfold, and the output register.
// The whole pipeline advances as one; it keeps moving while m_valid is low or
// m_ready is high, and stops only when a result waits and m_ready is low.
// s_ready is low only in that stalled case.
// Reset (aresetn low, synchronous) drops every item in flight and clears all
// valid flags; results do not survive reset.
module fixed_point_atan2_turns (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [fpat_pkg::MagW-1:0]    s_vec_x,
    input  logic signed [fpat_pkg::MagW-1:0]    s_vec_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fpat_pkg::AngleW-1:0]         m_angle
);
    localparam int unsigned Cells = fpat_pkg::QuotW;
    localparam int unsigned W = fpat_pkg::MagW;

    logic                 en;
    logic [W:0]           ax, ay;
    logic                 sw;
    fpat_pkg::div_t       f_reg, f_next;
    fpat_pkg::div_t       seed;
    fpat_pkg::div_t       chain [0:Cells];
    logic                 p_vld;
    logic [fpat_pkg::AngleW-1:0] p_ang;
    logic                 o_vld_reg;
    logic [fpat_pkg::AngleW-1:0] o_ang_reg;

    // Advance whenever the output slot is free or being emptied.
    assign en      = !o_vld_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        ax = s_vec_x[W-1] ? ({1'b0, ~s_vec_x} + 1'b1) : {1'b0, s_vec_x};
        ay = s_vec_y[W-1] ? ({1'b0, ~s_vec_y} + 1'b1) : {1'b0, s_vec_y};
        sw = ay > ax;
        f_next.vld         = s_valid;
        f_next.fold.zero   = (s_vec_x == '0) && (s_vec_y == '0);
        f_next.fold.mirror = s_vec_x[W-1];
        // math y = -vec_y: negative when vec_y is positive
        f_next.fold.negate = !s_vec_y[W-1] && (s_vec_y != '0);
        f_next.fold.swap   = sw;
        // lo<<16 / hi: start with rem = lo; the 2^16 digit is taken first
        f_next.rem = sw ? {1'b0, ax[W-1:0]} : {1'b0, ay[W-1:0]};
        f_next.dvs = sw ? ay[W-1:0] : ax[W-1:0];
        f_next.quo = '0;
        if (f_next.fold.zero) f_next.dvs = {{(W-1){1'b0}}, 1'b1};
    end

    // Take the 2^16 digit (lo >= hi) before the shifting cells.
    always_comb begin
        seed = f_reg;
        if (f_reg.rem[W-1:0] >= f_reg.dvs) begin
            seed.rem = f_reg.rem - {1'b0, f_reg.dvs};
            seed.quo = {{(Cells-1){1'b0}}, 1'b1};
        end else begin
            seed.quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg.vld <= 1'b0;
        end else if (en) begin
            f_reg.vld <= f_next.vld;
        end
        if (en) begin
            f_reg.fold <= f_next.fold;
            f_reg.rem  <= f_next.rem;
            f_reg.dvs  <= f_next.dvs;
            f_reg.quo  <= f_next.quo;
        end
    end

    assign chain[0] = seed;

    genvar gi;
    generate
        for (gi = 0; gi < Cells - 1; gi++) begin : g_div
            fpat_div_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .d_in    (chain[gi]),
                .d_out   (chain[gi+1])
            );
        end
    endgenerate
    assign chain[Cells] = chain[Cells-1];

    fpat_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (chain[Cells].vld),
        .in_fold   (chain[Cells].fold),
        .in_r      (chain[Cells].quo),
        .out_vld   (p_vld),
        .out_angle (p_ang)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= p_vld;
        end
        if (en) begin
            o_ang_reg <= p_ang;
        end
    end

    assign m_valid = o_vld_reg;
    assign m_angle = o_ang_reg;
endmodule

### hw/rtl/fpat_checker.sv
module fpat_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_angle
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle))
        else $error("result dropped while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind fixed_point_atan2_turns fpat_checker u_fpat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_angle (m_angle)
);

### bench/fixed_point_atan2_turns_chk.sv
module fixed_point_atan2_turns_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_vec_x,
    input  logic [31:0] s_vec_y,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_angle,
    output int          n_fail,
    output int          n_pending
);
    logic [15:0] angle_q[$];

    function automatic logic [15:0] vec_angle(logic [31:0] vx, logic [31:0] vy);
        logic signed [33:0] sx, sy;
        logic [33:0] ax, ay, lo, hi;
        logic [63:0] r, t, a;
        logic [15:0] res;
        logic mir, neg, swp;
        sx = {{2{vx[31]}}, vx};
        sy = -{{2{vy[31]}}, vy};
        if (sx == 0 && sy == 0) return fpat_pkg::ZeroAngle;
        mir = sx < 0;
        neg = sy < 0;
        ax = mir ? -sx : sx;
        ay = neg ? -sy : sy;
        swp = ay > ax;
        lo = swp ? ax : ay;
        hi = swp ? ay : ax;
        r = ({30'd0, lo} << 16) / {30'd0, hi};
        t = (64'(fpat_pkg::OctCurve) * (64'(fpat_pkg::FxOne) - r)) >> 16;
        a = (r * (64'(fpat_pkg::OctBase) + t)) >> 16;
        res = a[15:0];
        if (swp) res = fpat_pkg::Quarter - res;
        if (mir) res = fpat_pkg::Half - res;
        if (neg) res = 16'd0 - res;
        return res;
    endfunction

    initial n_fail = 0;
    initial n_pending = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) angle_q.push_back(vec_angle(s_vec_x, s_vec_y));
            if (m_valid && m_ready) begin
                if (angle_q.size() == 0) begin
                    if (n_fail < 10) $display("unexpected angle %h", m_angle);
                    n_fail <= n_fail + 1;
                end else begin
                    logic [15:0] want;
                    want = angle_q.pop_front();
                    if (want !== m_angle) begin
                        if (n_fail < 10)
                            $display("angle mismatch: expected %h got %h", want, m_angle);
                        n_fail <= n_fail + 1;
                    end
                end
            end
            n_pending <= angle_q.size();
        end
    end
endmodule

### bench/fixed_point_atan2_turns_tb.sv
module fixed_point_atan2_turns_tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_vec_x = 0;
    logic [31:0] s_vec_y = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_angle;
    int          n_fail, n_pending;
    int          cyc = 0;
    bit          calm = 0;
    bit          hold_off = 0;

    localparam int NumDirected = 24;
    localparam int NumRandom   = 1350;
    localparam int Limit       = 400000;

    fixed_point_atan2_turns DUT (.*);
    fixed_point_atan2_turns_chk chk (.*);

    initial forever #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > Limit) begin
            $display("fixed_point_atan2_turns_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_val();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 8) - 4;
            1: v = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000001;
            2: v = $urandom() >> $urandom_range(0, 31);
            default: v = $urandom();
        endcase
        if (v == 32'h80000000) v = 32'h80000001;
        return v;
    endfunction

    // receiver: random stalls, plus one long hold-off
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send(logic [31:0] x, logic [31:0] y);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_vec_x <= x;
        s_vec_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] dx[NumDirected];
        logic [31:0] dy[NumDirected];
        dx = '{0, 1, 0, 32'hFFFFFFFF, 0, 32'h7FFFFFFF, 32'h80000001, 0, 0,
               32'h7FFFFFFF, 32'h80000001, 32'h10000, 32'hFFFF0000, 5, 32'hFFFFFFFB,
               32'h7FFFFFFF, 1, 32'h12345, 32'h10000, 3, 32'h80000001, 7, 32'h7FFFFFFF, 2};
        dy = '{0, 0, 1, 0, 32'hFFFFFFFF, 0, 0, 32'h7FFFFFFF, 32'h80000001,
               32'h7FFFFFFF, 32'h80000001, 32'hFFFF0000, 32'h10000, 5, 5,
               1, 32'h7FFFFFFF, 32'h12344, 32'h10001, 32'hFFFFFFFD, 32'h7FFFFFFF, 7,
               32'h80000001, 32'hFFFFFFFE};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int i = 0; i < NumDirected; i++) send(dx[i], dy[i]);
        for (int i = 0; i < NumRandom; i++) begin
            if (i == 300) hold_off = 1;
            if (i == NumRandom - 200) calm = 1;
            send(pick_val(), pick_val());
        end
        s_valid <= 0;
        while (n_pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (n_fail == 0 && !m_valid)
            $display("fixed_point_atan2_turns_tb: done, clean");
        else
            $display("fixed_point_atan2_turns_tb: done, errors");
        $finish;
    end
endmodule

### files.f
hw/rtl/fpat_pkg.sv
hw/rtl/fpat_div_cell.sv
hw/rtl/fpat_poly.sv
hw/rtl/fixed_point_atan2_turns.sv
hw/rtl/fpat_checker.sv
bench/fixed_point_atan2_turns_chk.sv
bench/fixed_point_atan2_turns_tb.sv
